FILE: sv/sgm_pkg.sv
// Shared types and constants for the Sobel gradient magnitude block.
// Used by the top level and by its port checker; depends on nothing.
package sgm_pkg;

  localparam int PIX_W      = 8;
  localparam int WIDTH_W    = 12;
  localparam int HEIGHT_W   = 13;
  localparam int CFG_W      = 13;
  localparam int ROW_W      = 12;
  localparam int DIM_W      = 14;
  localparam int MIN_DIM    = 3;
  localparam int MAX_HEIGHT = 4096;
  localparam int ENTRY_W    = 2 * PIX_W;
  localparam int WIN_N      = 6;

  typedef enum logic [0:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic             last_in_frame;
    logic             last_in_line;
    logic [PIX_W-1:0] magnitude;
  } result_t;

endpackage

FILE: sv/sgm_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Used for the line store of the Sobel block; depends on nothing.
module sgm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/sobel_gradient_magnitude_top.sv
// Sobel gradient magnitude over a streamed grayscale frame.
// Depends on sgm_pkg and sgm_ram.
//
// Pixels enter on the in_ stream in raster order, one request per pixel, for a
// frame whose size is set through the cfg_ write port (index 0 width, 1 height).
// Each interior pixel yields one request on the out_ stream carrying the
// saturated sum of absolute horizontal and vertical gradients; border pixels are
// accepted and yield nothing. out_tlast marks the last result of a line and
// out_tuser marks the last result of the frame.
// A result is registered in the output register, or in the skid stage while the
// output stalls, once the pixel that completes its window is accepted. One pixel
// is taken every cycle while in_tready is high; that rate is set by the line
// store, which is read for the next column and written for the current one in
// the same cycle over its two ports. After reset the block holds in_tready low
// while the first line store read is issued; there is no clearing pass. When
// the receiver stalls, the output register and a one-entry skid stage keep
// pixels flowing until both are full, after which in_tready drops.
module sobel_gradient_magnitude_top #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [sgm_pkg::PIX_W-1:0]    in_tdata,   // [7:0] pixel
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [sgm_pkg::PIX_W-1:0]    out_tdata,  // [7:0] magnitude
  output logic                         out_tlast,
  output logic [0:0]                   out_tuser,  // [0] last_in_frame
  input  logic                         cfg_we,
  input  logic [0:0]                   cfg_index,
  input  logic [sgm_pkg::CFG_W-1:0]    cfg_wdata
);

  localparam int ColW  = $clog2(MAX_WIDTH);
  localparam int DimW  = sgm_pkg::DIM_W;
  localparam int RowW  = sgm_pkg::ROW_W;
  localparam int PixW  = sgm_pkg::PIX_W;
  localparam int EntW  = sgm_pkg::ENTRY_W;
  localparam int WidW  = sgm_pkg::WIDTH_W;
  localparam int HgtW  = sgm_pkg::HEIGHT_W;
  localparam logic [DimW-1:0] DimMin    = DimW'(sgm_pkg::MIN_DIM);
  localparam logic [DimW-1:0] WidthMax  = DimW'(MAX_WIDTH);
  localparam logic [DimW-1:0] HeightMax = DimW'(sgm_pkg::MAX_HEIGHT);
  localparam logic [ColW-1:0] ColFirst  = ColW'(2);
  localparam logic [RowW-1:0] RowFirst  = RowW'(2);

  logic [WidW-1:0]  width_r;
  logic [HgtW-1:0]  height_r;
  logic [ColW-1:0]  col_r, col_nxt;
  logic [RowW-1:0]  row_r, row_nxt;
  logic [PixW-1:0]  win_r [sgm_pkg::WIN_N];
  logic             primed_r;
  logic             out_valid_r, out_valid_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  sgm_pkg::result_t out_data_r, out_data_nxt;
  sgm_pkg::result_t skid_data_r, skid_data_nxt;
  sgm_pkg::result_t res;

  logic             accept, interior, produce, end_line, end_frame;
  logic [DimW-1:0]  w_ext, h_ext, w_eff, h_eff, col_p1, row_p1;
  logic [EntW-1:0]  entry;
  logic [ColW-1:0]  rd_addr;
  logic [PixW-1:0]  px, t0, m0, b0, t1, b1, t2, m2;
  logic [9:0]       sum_left, sum_right, sum_top, sum_bottom;
  logic signed [10:0] gx, gy;
  logic [9:0]       gx_abs, gy_abs;
  logic [10:0]      mag_sum;

  assign accept = in_tvalid && in_tready;
  assign px     = in_tdata;
  assign t2     = entry[EntW-1:PixW];
  assign m2     = entry[PixW-1:0];
  assign t0     = win_r[0];
  assign m0     = win_r[1];
  assign b0     = win_r[2];
  assign t1     = win_r[3];
  assign b1     = win_r[5];

  always_comb begin
    w_ext = DimW'(width_r);
    h_ext = DimW'(height_r);
    if (w_ext < DimMin) begin
      w_eff = DimMin;
    end else if (w_ext > WidthMax) begin
      w_eff = WidthMax;
    end else begin
      w_eff = w_ext;
    end
    if (h_ext < DimMin) begin
      h_eff = DimMin;
    end else if (h_ext > HeightMax) begin
      h_eff = HeightMax;
    end else begin
      h_eff = h_ext;
    end
    col_p1    = DimW'(col_r) + DimW'(1);
    row_p1    = DimW'(row_r) + DimW'(1);
    end_line  = (col_p1 >= w_eff);
    end_frame = end_line && (row_p1 >= h_eff);
    interior  = (row_r >= RowFirst) && (col_r >= ColFirst);
    produce   = accept && interior;
    if (end_line) begin
      col_nxt = '0;
      row_nxt = end_frame ? '0 : row_p1[RowW-1:0];
    end else begin
      col_nxt = col_p1[ColW-1:0];
      row_nxt = row_r;
    end
    rd_addr = accept ? col_nxt : col_r;
  end

  always_comb begin
    sum_left   = {2'b00, t0} + {1'b0, m0, 1'b0} + {2'b00, b0};
    sum_right  = {2'b00, t2} + {1'b0, m2, 1'b0} + {2'b00, px};
    sum_bottom = {2'b00, b0} + {1'b0, b1, 1'b0} + {2'b00, px};
    sum_top    = {2'b00, t0} + {1'b0, t1, 1'b0} + {2'b00, t2};
    gx         = $signed({1'b0, sum_left}) - $signed({1'b0, sum_right});
    gy         = $signed({1'b0, sum_bottom}) - $signed({1'b0, sum_top});
    gx_abs     = gx[10] ? 10'(-gx) : gx[9:0];
    gy_abs     = gy[10] ? 10'(-gy) : gy[9:0];
    mag_sum    = {1'b0, gx_abs} + {1'b0, gy_abs};
    res.magnitude     = (|mag_sum[10:PixW]) ? {PixW{1'b1}} : mag_sum[PixW-1:0];
    res.last_in_line  = end_line;
    res.last_in_frame = end_frame;
  end

  sgm_ram #(
    .WIDTH (EntW),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (accept),
    .waddr (col_r),
    .wdata ({m2, px}),
    .raddr (rd_addr),
    .rdata (entry)
  );

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = produce;
        skid_data_nxt  = res;
      end else begin
        out_valid_nxt  = produce;
        out_data_nxt   = res;
      end
    end else if (produce) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r      <= WidW'(640);
      height_r     <= HgtW'(480);
      col_r        <= '0;
      row_r        <= '0;
      primed_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
      for (int i = 0; i < sgm_pkg::WIN_N; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      primed_r     <= 1'b1;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
      if (cfg_we) begin
        unique case (sgm_pkg::cfg_idx_t'(cfg_index))
          sgm_pkg::CFG_WIDTH:  width_r  <= cfg_wdata[WidW-1:0];
          sgm_pkg::CFG_HEIGHT: height_r <= cfg_wdata[HgtW-1:0];
        endcase
      end
      if (accept) begin
        col_r    <= col_nxt;
        row_r    <= row_nxt;
        win_r[0] <= win_r[3];
        win_r[1] <= win_r[4];
        win_r[2] <= win_r[5];
        win_r[3] <= t2;
        win_r[4] <= m2;
        win_r[5] <= px;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign in_tready  = primed_r && !skid_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r.magnitude;
  assign out_tlast  = out_data_r.last_in_line;
  assign out_tuser  = out_data_r.last_in_frame;

endmodule

FILE: sv/sgm_checker.sv
// Port-level checker for the Sobel gradient magnitude block, bound to its top level.
// Depends on sgm_pkg and sobel_gradient_magnitude_top.
module sgm_port_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [sgm_pkg::PIX_W-1:0] out_tdata,
  input logic                      out_tlast,
  input logic [0:0]                out_tuser
);

  // The output queue is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output request present after reset");

  // Right after reset is released, in_tready stays low while the line store read is primed.
  a_prime_wait: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !in_tready)
    else $error("pixel accepted before the line store read was primed");

  // The end of a frame is always also the end of a line.
  a_frame_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> out_tlast)
    else $error("frame end without line end");

  // A stalled result holds its value.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser)))
    else $error("stalled result changed");

endmodule

bind sobel_gradient_magnitude_top sgm_port_checker u_sgm_port_checker (.*);
